[sv/rrs_pkg.sv]
// Shared types and constants for the round-robin / SJF task scheduler.
`timescale 1ns / 1ps
`default_nettype none
package rrs_pkg;

  localparam int unsigned OpArrival = 0;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READY = 2'd1,
    ST_RUN   = 2'd2,
    ST_DONE  = 2'd3
  } task_st_e;

  localparam logic [0:0] CfgMode    = 1'b0;
  localparam logic [0:0] CfgQuantum = 1'b1;

  // Request passed from the front end to the back end.
  typedef struct packed {
    logic        is_tick;
    logic [15:0] burst;
  } req_t;

  // Result item.
  typedef struct packed {
    logic [31:0] total_wait;
    logic [5:0]  ready_count;
    logic [4:0]  finished_task;
    logic        finished_valid;
    logic [4:0]  running_task;
    logic        running_valid;
    logic        table_full;
  } res_t;

endpackage
`default_nettype wire

[sv/rrs_front.sv]
// Front end: decodes a request into the two-entry request queue.
`timescale 1ns / 1ps
`default_nettype none
module rrs_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          opcode_i,
  input  wire logic [15:0]   burst_i,
  output rrs_pkg::req_t      q_data_o,
  output logic               q_valid_o,
  input  wire logic          q_ready_i
);
  import rrs_pkg::*;

  // Two-entry request queue.
  req_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rp_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  // Store classified request.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q].is_tick <= (opcode_i != 1'(OpArrival));
      mem_q[wp_q].burst   <= burst_i;
    end
  end

  // Advance pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

[sv/rrs_back.sv]
// Back end: task table, RR FIFO, serial SJF pick and ready count.
`timescale 1ns / 1ps
`default_nettype none
module rrs_back #(
  parameter int unsigned MaxTasks = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          mode_i,
  input  wire logic [15:0]   quantum_i,
  input  wire rrs_pkg::req_t q_data_i,
  input  wire logic          q_valid_i,
  output logic               q_ready_o,
  output rrs_pkg::res_t      res_o,
  output logic               res_valid_o,
  input  wire logic          res_ready_i
);
  import rrs_pkg::*;

  localparam int unsigned IdW  = $clog2(MaxTasks);
  localparam int unsigned CntW = $clog2(MaxTasks + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RRPOP = 6'b000010,
    S_RRCHK = 6'b000100,
    S_SCAN  = 6'b001000,
    S_RUN   = 6'b010000,
    S_CNT   = 6'b100000
  } st_e;

  st_e              st_q;
  logic [15:0]      burst_q [MaxTasks];
  task_st_e         stat_q [MaxTasks];
  logic [IdW-1:0]   fifo_q [MaxTasks];
  logic [IdW-1:0]   head_q;
  logic [CntW-1:0]  fcnt_q, tcnt_q, rdy_q;
  logic             cur_v_q;
  logic [IdW-1:0]   cur_q;
  logic [15:0]      slice_q;
  logic [31:0]      wait_q;
  logic [IdW-1:0]   idx_q;
  logic             best_v_q;
  logic [IdW-1:0]   best_q;
  logic [15:0]      best_b_q;
  logic             tick_q, full_q, fin_v_q;
  logic [IdW-1:0]   fin_q;
  logic             run_v_q;
  logic [IdW-1:0]   run_id_q;
  logic [IdW-1:0]   pop_id_q;
  res_t             res_q;
  logic             res_v_q;
  logic [IdW-1:0]   tail, cur_tail;
  logic [CntW:0]    tail_sum;

  assign q_ready_o   = (st_q == S_IDLE) && !res_v_q;
  assign res_o       = res_q;
  assign res_valid_o = res_v_q;
  // Wrap the FIFO tail with a compare and subtract.
  assign tail_sum = (CntW+1)'(head_q) + (CntW+1)'(fcnt_q);
  assign tail     = (tail_sum >= (CntW+1)'(MaxTasks)) ?
                    IdW'(tail_sum - (CntW+1)'(MaxTasks)) : IdW'(tail_sum);
  assign cur_tail = tail;

  // Sequencer for one request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      for (int i = 0; i < MaxTasks; i++) stat_q[i] <= ST_IDLE;
      head_q  <= '0;
      fcnt_q  <= '0;
      tcnt_q  <= '0;
      cur_v_q <= 1'b0;
      slice_q <= '0;
      res_v_q <= 1'b0;
      idx_q   <= '0;
      rdy_q   <= '0;
      tick_q  <= 1'b0;
      full_q  <= 1'b0;
      fin_v_q <= 1'b0;
      run_v_q <= 1'b0;
    end else begin
      if (res_v_q && res_ready_i) res_v_q <= 1'b0;
      case (st_q)
        S_IDLE: if (q_valid_i && !res_v_q) begin
          tick_q  <= q_data_i.is_tick;
          full_q  <= 1'b0;
          fin_v_q <= 1'b0;
          idx_q   <= '0;
          rdy_q   <= '0;
          if (!q_data_i.is_tick) begin
            // Register arrival.
            if (tcnt_q >= CntW'(MaxTasks)) begin
              full_q <= 1'b1;
            end else begin
              burst_q[tcnt_q[IdW-1:0]] <= q_data_i.burst;
              tcnt_q <= tcnt_q + CntW'(1);
              if (q_data_i.burst == '0) begin
                stat_q[tcnt_q[IdW-1:0]] <= ST_DONE;
              end else begin
                stat_q[tcnt_q[IdW-1:0]] <= ST_READY;
                if (!mode_i && fcnt_q < CntW'(MaxTasks)) begin
                  fifo_q[tail] <= tcnt_q[IdW-1:0];
                  fcnt_q <= fcnt_q + CntW'(1);
                end
              end
            end
            st_q <= S_CNT;
          end else if (cur_v_q && !mode_i && slice_q == '0) begin
            // Requeue expired task.
            stat_q[cur_q] <= ST_READY;
            if (fcnt_q < CntW'(MaxTasks)) begin
              fifo_q[cur_tail] <= cur_q;
              fcnt_q <= fcnt_q + CntW'(1);
            end
            cur_v_q <= 1'b0;
            st_q    <= S_RRPOP;
          end else if (cur_v_q) begin
            st_q <= S_RUN;
          end else begin
            best_v_q <= 1'b0;
            st_q <= mode_i ? S_SCAN : S_RRPOP;
          end
        end
        S_RRPOP: begin
          if (fcnt_q == '0) begin
            st_q <= S_RUN;
          end else begin
            pop_id_q <= fifo_q[head_q];
            head_q   <= (head_q == IdW'(MaxTasks - 1)) ? '0 : head_q + IdW'(1);
            fcnt_q   <= fcnt_q - CntW'(1);
            st_q     <= S_RRCHK;
          end
        end
        S_RRCHK: begin
          if (stat_q[pop_id_q] == ST_READY) begin
            cur_v_q <= 1'b1;
            cur_q   <= pop_id_q;
            stat_q[pop_id_q] <= ST_RUN;
            slice_q <= (quantum_i == '0) ? 16'd1 : quantum_i;
            st_q    <= S_RUN;
          end else begin
            st_q <= S_RRPOP;
          end
        end
        S_SCAN: begin
          // One slot per cycle; strict less keeps the lower id.
          if (stat_q[idx_q] == ST_READY &&
              (!best_v_q || burst_q[idx_q] < best_b_q)) begin
            best_v_q <= 1'b1;
            best_q   <= idx_q;
            best_b_q <= burst_q[idx_q];
          end
          if (idx_q == IdW'(MaxTasks - 1)) begin
            idx_q <= '0;
            st_q  <= S_RUN;
            if (stat_q[idx_q] == ST_READY &&
                (!best_v_q || burst_q[idx_q] < best_b_q)) begin
              cur_v_q <= 1'b1;
              cur_q   <= idx_q;
              stat_q[idx_q] <= ST_RUN;
              slice_q <= (quantum_i == '0) ? 16'd1 : quantum_i;
            end else if (best_v_q) begin
              cur_v_q <= 1'b1;
              cur_q   <= best_q;
              stat_q[best_q] <= ST_RUN;
              slice_q <= (quantum_i == '0) ? 16'd1 : quantum_i;
            end
          end else begin
            idx_q <= idx_q + IdW'(1);
          end
        end
        S_RUN: begin
          // Run the current task one unit.
          run_v_q  <= cur_v_q;
          run_id_q <= cur_q;
          if (cur_v_q) begin
            if (burst_q[cur_q] != '0) burst_q[cur_q] <= burst_q[cur_q] - 16'd1;
            if (slice_q != '0) slice_q <= slice_q - 16'd1;
            if (burst_q[cur_q] <= 16'd1) begin
              fin_v_q <= 1'b1;
              fin_q   <= cur_q;
              stat_q[cur_q] <= ST_DONE;
              cur_v_q <= 1'b0;
            end
          end
          idx_q <= '0;
          st_q  <= S_CNT;
        end
        S_CNT: begin
          // Count ready slots serially, then emit.
          rdy_q <= rdy_q + CntW'(stat_q[idx_q] == ST_READY);
          if (idx_q == IdW'(MaxTasks - 1)) begin
            st_q <= S_IDLE;
            idx_q <= '0;
          end else begin
            idx_q <= idx_q + IdW'(1);
          end
        end
        default: st_q <= S_IDLE;
      endcase
      // Finish the result the cycle after the count completes.
      if (st_q == S_CNT && idx_q == IdW'(MaxTasks - 1)) begin
        res_v_q <= 1'b1;
      end
    end
  end

  // Result fields that follow the final count.
  logic [CntW-1:0] rdy_fin;
  assign rdy_fin = rdy_q + CntW'(stat_q[idx_q] == ST_READY);
  logic [32:0] wsum_fin;
  assign wsum_fin = {1'b0, wait_q} + 33'(rdy_fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q <= '0;
    end else if (st_q == S_CNT && idx_q == IdW'(MaxTasks - 1) && tick_q) begin
      wait_q <= wsum_fin[32] ? 32'hFFFF_FFFF : wsum_fin[31:0];
    end
  end

  // Load the result register when the count completes.
  always_ff @(posedge clk_i) begin
    if (st_q == S_CNT && idx_q == IdW'(MaxTasks - 1)) begin
      res_q.table_full     <= full_q;
      res_q.running_valid  <= tick_q && run_v_q;
      res_q.running_task   <= (tick_q && run_v_q) ? 5'(run_id_q) : 5'd0;
      res_q.finished_valid <= fin_v_q;
      res_q.finished_task  <= fin_v_q ? 5'(fin_q) : 5'd0;
      res_q.ready_count    <= 6'(rdy_fin);
      res_q.total_wait     <= !tick_q ? wait_q :
                              (wsum_fin[32] ? 32'hFFFF_FFFF : wsum_fin[31:0]);
    end
  end
endmodule
`default_nettype wire

[sv/rr_sjf_task_scheduler_top.sv]
// Top level of the round-robin / shortest-job-first task scheduler.
// Channel  | Dir | Payload
// s_axis   | in  | tuser[0] opcode, tdata[15:0] burst_length
// m_axis   | out | tdata: see port comment
// cfg      | in  | cfg_index_i selects register, cfg_data_i value
// Arrival: the result follows a serial ready count over all slots.
// Tick: in SJF when a pick is needed, a slot scan, then the run step and the count;
// otherwise the run step and the count; RR first pops FIFO entries until one is
// ready or none is left. The back end starts the next request only after
// the result is accepted. Reset clears all control state at once; no clearing pass.
// The front queue takes up to two requests while the back end works or the output stalls.
`timescale 1ns / 1ps
`default_nettype none
module rr_sjf_task_scheduler_top #(
  parameter int unsigned MaxTasks = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // burst_length[15:0]
  input  wire logic        s_axis_tuser,  // opcode[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // table_full[0], running_valid[1], running_task[6:2], finished_valid[7],
  // finished_task[12:8], ready_count[18:13], total_wait[50:19]
  output logic [55:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import rrs_pkg::*;

  req_t        req;
  logic        req_v, req_r;
  res_t        res;
  logic        mode_q;
  logic [15:0] quant_q;

  assign cfg_ready_o = 1'b1;

  // Hold configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      quant_q <= 16'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgMode:    mode_q  <= cfg_data_i[0];
        CfgQuantum: quant_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rrs_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .opcode_i(s_axis_tuser), .burst_i(s_axis_tdata),
    .q_data_o(req), .q_valid_o(req_v), .q_ready_i(req_r)
  );

  rrs_back #(.MaxTasks(MaxTasks)) u_back (
    .clk_i, .rst_ni,
    .mode_i(mode_q), .quantum_i(quant_q),
    .q_data_i(req), .q_valid_i(req_v), .q_ready_o(req_r),
    .res_o(res), .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {5'd0, res.total_wait, res.ready_count, res.finished_task,
                         res.finished_valid, res.running_task, res.running_valid,
                         res.table_full};
endmodule
`default_nettype wire

[sv/rrs_checker.sv]
// Port-level checker for the scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rrs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [55:0] m_axis_tdata
);
  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // Finished implies ran.
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[7] |-> m_axis_tdata[1])
    else $error("finish without run");
  // Full arrival reports no run.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[1])
    else $error("full flag on a tick");
endmodule
bind rr_sjf_task_scheduler_top rrs_checker u_chk (.*);
`default_nettype wire

[verif/rr_sjf_task_scheduler_top_tb.sv]
// Self-checking testbench for the round-robin / SJF task scheduler top level.
`timescale 1ns / 1ps
`default_nettype none
module rr_sjf_task_scheduler_top_tb;
  import rrs_pkg::*;

  localparam int unsigned NumSlots = 32;
  localparam int unsigned NoTask = NumSlots;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned DrainCycles = 200;
  localparam logic OpTick = 1'b1;

  typedef struct packed {
    logic        is_tick;
    logic [15:0] burst;
  } sched_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [0:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  rr_sjf_task_scheduler_top u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Generate clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scheduler shadow state.
  logic        sched_mode;
  logic [15:0] sched_quantum;
  logic [15:0] burst_left [NumSlots];
  task_st_e    slot_state [NumSlots];
  int unsigned run_fifo [NumSlots];
  int unsigned fifo_head, fifo_cnt, slots_used, cur_task, slice_cnt;
  logic [31:0] wait_sum;

  sched_req_t  pending_reqs [$];
  res_t        expected_res [$];
  int unsigned errors = 0, reqs_sent = 0, results_seen = 0, ticks_sent = 0;
  int unsigned fulls_seen = 0, finishes_seen = 0;
  int unsigned src_idle_pct = 0, sink_idle_pct = 0, idle_cycles = 0;
  bit          sink_hold = 1'b0;
  bit          in_taken = 1'b0;

  function automatic int unsigned count_ready_slots();
    int unsigned n;
    n = 0;
    for (int i = 0; i < NumSlots; i++) if (slot_state[i] == ST_READY) n++;
    return n;
  endfunction

  function automatic void push_run(int unsigned id);
    if (fifo_cnt >= NumSlots) return;
    run_fifo[(fifo_head + fifo_cnt) % NumSlots] = id;
    fifo_cnt++;
  endfunction

  function automatic int unsigned pop_runnable();
    int unsigned id;
    while (fifo_cnt > 0) begin
      id = run_fifo[fifo_head];
      fifo_head = (fifo_head + 1) % NumSlots;
      fifo_cnt--;
      if (slot_state[id] == ST_READY) return id;
    end
    return NoTask;
  endfunction

  function automatic int unsigned shortest_ready();
    int unsigned best;
    best = NoTask;
    for (int i = 0; i < NumSlots; i++)
      if (slot_state[i] == ST_READY &&
          (best == NoTask || burst_left[i] < burst_left[best])) best = i;
    return best;
  endfunction

  // Advance the shadow scheduler by one request and return its result.
  function automatic res_t predict_sched(sched_req_t r);
    res_t        res;
    int unsigned rdy, id;
    res = '0;
    if (!r.is_tick) begin
      if (slots_used >= NumSlots) res.table_full = 1'b1;
      else begin
        id = slots_used++;
        burst_left[id] = r.burst;
        if (r.burst == 0) slot_state[id] = ST_DONE;
        else begin
          slot_state[id] = ST_READY;
          if (!sched_mode) push_run(id);
        end
      end
      rdy = count_ready_slots();
    end else begin
      if (cur_task < NumSlots && !sched_mode && slice_cnt == 0) begin
        slot_state[cur_task] = ST_READY;
        push_run(cur_task);
        cur_task = NoTask;
      end
      if (cur_task >= NumSlots) begin
        cur_task = sched_mode ? shortest_ready() : pop_runnable();
        if (cur_task < NumSlots) begin
          slot_state[cur_task] = ST_RUN;
          slice_cnt = (sched_quantum != 0) ? sched_quantum : 1;
        end
      end
      if (cur_task < NumSlots) begin
        res.running_valid = 1'b1;
        res.running_task = 5'(cur_task);
        if (burst_left[cur_task] > 0) burst_left[cur_task]--;
        if (slice_cnt > 0) slice_cnt--;
        if (burst_left[cur_task] == 0) begin
          res.finished_valid = 1'b1;
          res.finished_task = 5'(cur_task);
          slot_state[cur_task] = ST_DONE;
          cur_task = NoTask;
        end
      end
      rdy = count_ready_slots();
      if ({1'b0, wait_sum} + 33'(rdy) > 33'hFFFF_FFFF) wait_sum = '1;
      else wait_sum += rdy;
    end
    res.ready_count = 6'(rdy);
    res.total_wait = wait_sum;
    return res;
  endfunction

  // Drive requests from the pending queue.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !in_taken) begin
        // hold current request
      end else if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_reqs[0].burst;
        s_axis_tuser <= pending_reqs[0].is_tick;
        void'(pending_reqs.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Predict on accepted requests, check accepted results, watch for hangs.
  always @(posedge clk_i) begin
    res_t got, exp_r;
    sched_req_t acc;
    in_taken <= s_axis_tvalid && s_axis_tready && rst_ni;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        acc.is_tick = s_axis_tuser;
        acc.burst = s_axis_tdata;
        expected_res.push_back(predict_sched(acc));
        reqs_sent++;
        if (acc.is_tick) ticks_sent++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[50:0]);
        results_seen++;
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          exp_r = expected_res.pop_front();
          if (got.table_full) fulls_seen++;
          if (got.finished_valid) finishes_seen++;
          if (got !== exp_r) begin
            errors++;
            $display("%0t: mismatch exp full=%0d run=%0d/%0d fin=%0d/%0d rdy=%0d wait=%0d",
                     $time, exp_r.table_full, exp_r.running_valid, exp_r.running_task,
                     exp_r.finished_valid, exp_r.finished_task, exp_r.ready_count,
                     exp_r.total_wait);
            $display("%0t:          got full=%0d run=%0d/%0d fin=%0d/%0d rdy=%0d wait=%0d",
                     $time, got.table_full, got.running_valid, got.running_task,
                     got.finished_valid, got.finished_task, got.ready_count,
                     got.total_wait);
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o) || sink_hold) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("%0t: no progress, %0d results outstanding", $time, expected_res.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // Write one register while the block is idle.
  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgMode) sched_mode = val[0];
    else sched_quantum = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic add_req(logic tick, logic [15:0] burst);
    sched_req_t r;
    r.is_tick = tick;
    r.burst = burst;
    pending_reqs.push_back(r);
  endtask

  // Random phase: task batches, with mostly ticks to keep them running.
  task automatic random_phase(int unsigned n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1: add_req(~OpTick, ($urandom_range(7) == 0) ? 16'($urandom) :
                      ($urandom_range(15) == 0 ? 16'd0 : 16'($urandom_range(1, 12))));
        2: add_req(OpTick, 16'($urandom));
        default: add_req(OpTick, 16'd0);
      endcase
    end
  endtask

  initial begin
    int unsigned phase;
    sched_mode = 1'b0;
    sched_quantum = 16'd1;
    for (int i = 0; i < NumSlots; i++) begin
      slot_state[i] = ST_IDLE;
      burst_left[i] = '0;
      run_fifo[i] = 0;
    end
    fifo_head = 0; fifo_cnt = 0; slots_used = 0; cur_task = NoTask;
    slice_cnt = 0; wait_sum = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: RR with quantum 1, extreme bursts, zero burst.
    add_req(~OpTick, 16'hFFFF);
    add_req(~OpTick, 16'd0);
    add_req(~OpTick, 16'd1);
    add_req(~OpTick, 16'd2);
    repeat (5) add_req(OpTick, 16'hFFFF);
    wait_drained();
    // Switch to SJF mid-stream: FIFO is ignored, shortest then lower id wins.
    write_reg(CfgMode, 16'd1);
    add_req(~OpTick, 16'd3);
    add_req(~OpTick, 16'd3);
    add_req(~OpTick, 16'hAAAA);
    repeat (8) add_req(OpTick, 16'h5555);
    wait_drained();

    // Random phases over modes and quanta; table fills as ids run out.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin src_idle_pct = 6; sink_idle_pct = 79; end
        2: begin src_idle_pct = 79; sink_idle_pct = 6; end
        4: begin src_idle_pct = 0; sink_idle_pct = 0; end
        default: ;
      endcase
      write_reg(CfgMode, 16'($urandom_range(1)) | 16'hFFFE);
      write_reg(CfgQuantum, (phase == 1) ? 16'hFFFF : (phase == 3) ? 16'd0 :
                16'($urandom_range(1, 5)));
      if (phase == 4) begin
        // Hold the output side off long enough for the input to back up.
        sink_hold = 1'b1;
        random_phase(60);
        repeat (3000) @(posedge clk_i);
        sink_hold = 1'b0;
      end
      random_phase(225);
      wait_drained();
      write_reg(CfgMode, 16'($urandom_range(1)));
      random_phase(30);
      wait_drained();
    end

    $display("Ran %0d requests (%0d ticks), %0d results, %0d table-full, %0d finishes.",
             reqs_sent, ticks_sent, results_seen, fulls_seen, finishes_seen);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

[rr_sjf_task_scheduler_top.f]
sv/rrs_pkg.sv
sv/rrs_front.sv
sv/rrs_back.sv
sv/rr_sjf_task_scheduler_top.sv
sv/rrs_checker.sv
verif/rr_sjf_task_scheduler_top_tb.sv
